// File: rtl/core/odeint_pkg.sv
package odeint_pkg;

    localparam int QW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 11;
    localparam int MAX_STEPS = 1024;
    localparam int QDEPTH    = 2;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;
    localparam logic signed [QW-1:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    localparam logic [QW-1:0] RECIP6       = 32'hAAAA_AAAB;
    localparam int            RECIP6_SHIFT = 34;

    localparam logic [1:0] METH_EULER = 2'd0;
    localparam logic [1:0] METH_RK2   = 2'd1;

    localparam logic CFG_METHOD   = 1'b0;
    localparam logic CFG_EQUATION = 1'b1;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] h;
        logic [CNT_W-1:0]     n;
        logic                 ovf;
    } job_t;

    function automatic logic signed [QW:0] sat_chk(input logic signed [QW+32:0] v);
        logic signed [QW:0] r;
        if (v > $signed({{33{1'b0}}, Q_MAX}))
            r = {1'b1, Q_MAX};
        else if (v < $signed({{33{1'b1}}, Q_MIN}))
            r = {1'b1, Q_MIN};
        else
            r = {1'b0, v[QW-1:0]};
        return r;
    endfunction

endpackage

// File: rtl/core/odeint_front.sv
module odeint_front
    import odeint_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [QW-1:0] x_start,
    input  logic signed [QW-1:0] y_start,
    input  logic signed [QW-1:0] x_stop,
    input  logic [CNT_W-1:0]     step_count,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    typedef enum logic [1:0] {IDLE, DIVIDE, SIGN, DONE} state_t;

    state_t               state_reg;
    logic [5:0]           bit_reg;
    logic [QW:0]          quo_reg;
    logic [QW+1:0]        rem_reg;
    logic [QW:0]          num_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     n_reg;
    logic signed [QW-1:0] x_reg;
    logic signed [QW-1:0] y_reg;
    logic signed [QW-1:0] h_reg;
    logic                 hovf_reg;

    logic signed [QW:0]   diff;
    logic [CNT_W-1:0]     n_clamp;
    logic [QW+1:0]        rem_shift;
    logic signed [QW+1:0] q_signed;
    logic signed [QW:0]   q_sat;

    assign diff      = {x_stop[QW-1], x_stop} - {x_start[QW-1], x_start};
    assign n_clamp   = (step_count > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : step_count;
    assign rem_shift = {rem_reg[QW:0], num_reg[QW]};
    assign q_signed  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign q_sat     = sat_chk((QW+33)'(q_signed));

    assign full      = (state_reg != IDLE);
    assign job_valid = (state_reg == DONE);
    assign job       = '{x: x_reg, y: y_reg, h: h_reg, n: n_reg, ovf: hovf_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            bit_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            num_reg   <= '0;
            neg_reg   <= 1'b0;
            n_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            h_reg     <= '0;
            hovf_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (push)
                    begin
                        x_reg    <= x_start;
                        y_reg    <= y_start;
                        n_reg    <= n_clamp;
                        neg_reg  <= diff[QW];
                        num_reg  <= diff[QW] ? (QW+1)'(0) - diff : diff;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        bit_reg  <= 6'(QW + 1);
                        hovf_reg <= 1'b0;
                        h_reg    <= '0;
                        state_reg <= (n_clamp == '0) ? DONE : DIVIDE;
                    end
                end
                DIVIDE:
                begin
                    if (rem_shift >= {{(QW+2-CNT_W){1'b0}}, n_reg})
                    begin
                        rem_reg <= rem_shift - {{(QW+2-CNT_W){1'b0}}, n_reg};
                        quo_reg <= {quo_reg[QW-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[QW-1:0], 1'b0};
                    end
                    num_reg <= {num_reg[QW-1:0], 1'b0};
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd1)
                        state_reg <= SIGN;
                end
                SIGN:
                begin
                    h_reg     <= q_sat[QW-1:0];
                    hovf_reg  <= q_sat[QW];
                    state_reg <= DONE;
                end
                DONE:
                begin
                    if (job_ready)
                        state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIVIDE) |-> (bit_reg != '0))
        else $error("divider ran past last bit");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front took word but not busy");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE && push && step_count == '0) |=> (state_reg == DONE))
        else $error("zero count must skip divide");
`endif

endmodule

// File: rtl/core/odeint_fifo.sv
module odeint_fifo
    import odeint_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t       mem_reg [QDEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH))
        else $error("queue count out of range");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == 2'(QDEPTH)) |-> (wp_reg == rp_reg))
        else $error("queue pointers disagree with count");
    a_ovr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH) && !rd_en) |=> (cnt_reg == 2'(QDEPTH)))
        else $error("queue overrun");
`endif

endmodule

// File: rtl/core/odeint_back.sv
module odeint_back
    import odeint_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           method_select,
    input  logic                 equation_select,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  job_t                 job,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [QW-1:0] y_final,
    output logic                 overflow
);

    typedef enum logic [3:0] {
        IDLE, STEP, SLOPE_A, SLOPE_B, SLOPE_M, INC_MUL, INC_ABS, INC_SIX, INC_ADD, ACC,
        UPDATE, DONE
    } state_t;

    state_t               state_reg;
    logic signed [QW-1:0] x_reg;
    logic signed [QW-1:0] y_reg;
    logic signed [QW-1:0] h_reg;
    logic [CNT_W-1:0]     left_reg;
    logic                 ovf_reg;
    logic [1:0]           stage_reg;
    logic signed [QW-1:0] xs_reg;
    logic signed [QW-1:0] ys_reg;
    logic signed [QW-1:0] k_reg;
    logic signed [QW-1:0] sum_reg;
    logic signed [QW-1:0] t_reg;
    logic signed [63:0]   prod_reg;
    logic                 final_reg;
    logic                 six_neg_reg;
    logic [QW-1:0]        six_mag_reg;
    logic signed [QW-1:0] six_q_reg;
    logic                 out_valid_reg;
    logic signed [QW-1:0] out_y_reg;
    logic                 out_ovf_reg;

    logic [1:0]           meth;
    logic                 is_rk4;
    logic signed [QW-1:0] mul_a;
    logic signed [QW-1:0] mul_b;
    logic signed [QW:0]   r_xh;
    logic signed [QW:0]   r_xhalf;
    logic signed [QW:0]   r_xy;
    logic signed [QW:0]   r_pp;
    logic signed [QW:0]   r_sh;
    logic signed [QW:0]   r_inc;
    logic signed [QW:0]   r_acc;
    logic signed [QW:0]   r_acc2;
    logic signed [QW:0]   x_next;
    logic signed [QW-1:0] t_src;
    logic signed [QW:0]   r_t;
    logic                 t_ovf;
    logic signed [QW-1:0] prod_q;
    logic signed [QW-1:0] inc_div;
    logic signed [QW-1:0] half_h;
    logic [63:0]          six_prod;
    logic signed [QW-1:0] six_quot;

    function automatic logic signed [QW:0] qadd(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
        return sat_chk((QW+33)'(a) + (QW+33)'(b));
    endfunction

    assign meth    = (method_select == 2'd3) ? 2'd2 : method_select;
    assign is_rk4  = (meth != METH_EULER) && (meth != METH_RK2);
    assign half_h  = h_reg / 2;
    assign r_xh    = qadd(x_reg, h_reg);
    assign r_xhalf = qadd(x_reg, half_h);
    assign r_xy    = qadd(xs_reg, ys_reg);
    assign r_sh    = sat_chk((QW+33)'(prod_reg >>> FRAC_BITS));
    assign prod_q  = r_sh[QW-1:0];
    assign r_pp    = qadd(prod_q, prod_q);
    assign six_prod = 64'(six_mag_reg) * 64'(RECIP6);
    assign six_quot = $signed(QW'(six_prod >> RECIP6_SHIFT));
    assign inc_div = (meth == METH_EULER) ? prod_q :
                     (meth == METH_RK2)   ? (final_reg ? prod_q / 2 : prod_q) :
                     final_reg            ? six_q_reg :
                     (stage_reg == 2'd2)  ? prod_q : prod_q / 2;
    assign r_inc   = qadd(y_reg, inc_div);
    assign r_acc   = qadd(sum_reg, k_reg);
    assign r_acc2  = qadd(r_acc[QW-1:0], k_reg);
    assign x_next  = (meth == METH_RK2 || stage_reg == 2'd2) ? r_xh : r_xhalf;
    assign t_src   = (state_reg == STEP) ? x_reg : x_next[QW-1:0];
    assign r_t     = qadd(t_src, Q_ONE);
    assign t_ovf   = r_t[QW] && !equation_select;

    assign mul_a = (state_reg == SLOPE_A) ? ys_reg : h_reg;
    assign mul_b = (state_reg == SLOPE_A) ? t_reg : (final_reg ? sum_reg : k_reg);

    assign job_ready = (state_reg == IDLE);
    assign empty     = !out_valid_reg;
    assign y_final   = out_y_reg;
    assign overflow  = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            x_reg <= '0; y_reg <= '0; h_reg <= '0; left_reg <= '0; ovf_reg <= 1'b0;
            stage_reg <= '0; xs_reg <= '0; ys_reg <= '0; k_reg <= '0; sum_reg <= '0;
            t_reg <= '0; prod_reg <= '0; final_reg <= 1'b0;
            six_neg_reg <= 1'b0; six_mag_reg <= '0; six_q_reg <= '0;
            out_valid_reg <= 1'b0;
            out_y_reg     <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == DONE && (!out_valid_reg || pop))
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:
                begin
                    if (job_valid)
                    begin
                        x_reg <= job.x; y_reg <= job.y; h_reg <= job.h;
                        left_reg <= job.n; ovf_reg <= job.ovf;
                        state_reg <= STEP;
                    end
                end
                STEP:
                begin
                    if (left_reg == '0)
                        state_reg <= DONE;
                    else
                    begin
                        stage_reg <= '0; final_reg <= 1'b0;
                        xs_reg <= x_reg; ys_reg <= y_reg;
                        t_reg <= r_t[QW-1:0];
                        ovf_reg <= ovf_reg | t_ovf;
                        state_reg <= SLOPE_A;
                    end
                end
                SLOPE_A:
                begin
                    if (equation_select)
                        state_reg <= SLOPE_B;
                    else
                    begin
                        prod_reg <= 64'(mul_a) * 64'(mul_b);
                        state_reg <= SLOPE_M;
                    end
                end
                SLOPE_M:
                begin
                    ovf_reg <= ovf_reg | r_sh[QW] | r_pp[QW];
                    k_reg <= r_pp[QW-1:0];
                    state_reg <= ACC;
                end
                SLOPE_B:
                begin
                    ovf_reg <= ovf_reg | r_xy[QW];
                    k_reg <= r_xy[QW-1:0];
                    state_reg <= ACC;
                end
                ACC:
                begin
                    if (stage_reg == '0)
                        sum_reg <= k_reg;
                    else if (stage_reg == 2'd3 || meth == METH_RK2)
                    begin
                        sum_reg <= r_acc[QW-1:0];
                        ovf_reg <= ovf_reg | r_acc[QW];
                    end
                    else
                    begin
                        sum_reg <= r_acc2[QW-1:0];
                        ovf_reg <= ovf_reg | r_acc[QW] | r_acc2[QW];
                    end
                    if (meth == METH_EULER || stage_reg == 2'd3 ||
                        (meth == METH_RK2 && stage_reg == 2'd1))
                        final_reg <= 1'b1;
                    state_reg <= INC_MUL;
                end
                INC_MUL:
                begin
                    prod_reg <= 64'(mul_a) * 64'(mul_b);
                    state_reg <= (final_reg && is_rk4) ? INC_ABS : INC_ADD;
                end
                INC_ABS:
                begin
                    six_neg_reg <= prod_q[QW-1];
                    six_mag_reg <= prod_q[QW-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
                    state_reg <= INC_SIX;
                end
                INC_SIX:
                begin
                    six_q_reg <= six_neg_reg ? -six_quot : six_quot;
                    state_reg <= INC_ADD;
                end
                INC_ADD:
                begin
                    ys_reg <= r_inc[QW-1:0];
                    if (final_reg || meth == METH_EULER)
                    begin
                        ovf_reg <= ovf_reg | r_sh[QW] | r_inc[QW];
                        state_reg <= UPDATE;
                    end
                    else
                    begin
                        ovf_reg <= ovf_reg | r_sh[QW] | r_inc[QW] | x_next[QW] | t_ovf;
                        stage_reg <= stage_reg + 2'd1;
                        xs_reg <= x_next[QW-1:0];
                        t_reg <= r_t[QW-1:0];
                        state_reg <= SLOPE_A;
                    end
                end
                UPDATE:
                begin
                    y_reg <= ys_reg;
                    x_reg <= r_xh[QW-1:0];
                    ovf_reg <= ovf_reg | r_xh[QW];
                    left_reg <= left_reg - CNT_W'(1);
                    state_reg <= STEP;
                end
                DONE:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_y_reg <= y_reg;
                        out_ovf_reg <= ovf_reg;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> (state_reg == STEP))
        else $error("back did not start on taken job");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == UPDATE) |-> (left_reg != '0))
        else $error("step count underflow");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DONE && !out_valid_reg) |=> !empty)
        else $error("result word lost");
`endif

endmodule

// File: rtl/core/ode_integrator_euler_rk2_rk4.sv
// Fixed-step ODE solver in signed Q16.16: each pushed word (x_start, y_start,
// x_stop, step_count) returns one word with y at x_stop and an overflow flag.
// A front end divides the span by the step count (one quotient bit a cycle,
// then a step to apply the sign) and queues the job; the back end runs the
// steps on one shared 32x32 multiplier, with a separate constant multiply by
// 1/6 for the RK4 sum. The front takes a new word while the back end works,
// up to two queued jobs.
// method_select (index 0, reset 2) and equation_select (index 1, reset 0) are
// to be written by the user only while idle; the block does not enforce it.
module ode_integrator_euler_rk2_rk4
    import odeint_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [1:0]           cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic signed [QW-1:0] x_start,
    input  logic signed [QW-1:0] y_start,
    input  logic signed [QW-1:0] x_stop,
    input  logic [CNT_W-1:0]     step_count,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [QW-1:0] y_final,
    output logic                 overflow
);

    logic [1:0] method_reg;
    logic       equation_reg;
    logic       fj_valid;
    logic       fj_ready;
    job_t       fj;
    logic       bj_valid;
    logic       bj_ready;
    job_t       bj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg   <= 2'd2;
            equation_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_METHOD:   method_reg   <= cfg_data;
                CFG_EQUATION: equation_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    odeint_front u_front (
        .clk, .rst_n, .push, .full, .x_start, .y_start, .x_stop, .step_count,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    odeint_fifo u_fifo (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    odeint_back u_back (
        .clk, .rst_n, .method_select(method_reg), .equation_select(equation_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .empty, .pop, .y_final, .overflow
    );

endmodule

// File: dv/ode_integrator_euler_rk2_rk4_tb.sv
module ode_integrator_euler_rk2_rk4_tb;
    import odeint_pkg::*;

    localparam logic [1:0] METH_RK4     = 2'd2;
    localparam logic [1:0] METH_RK4_ALT = 2'd3;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic signed [QW-1:0] y;
        logic                 ovf;
    } solution_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [1:0]           cfg_data;
    logic                 push;
    logic                 full;
    logic signed [QW-1:0] x_start;
    logic signed [QW-1:0] y_start;
    logic signed [QW-1:0] x_stop;
    logic [CNT_W-1:0]     step_count;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [QW-1:0] y_final;
    logic                 overflow;

    solution_t  pending_solutions[$];
    logic [1:0] method_mirror;
    logic       equation_mirror;
    bit         sat_seen;
    int         mismatch_count = 0;
    int         burst_left;
    int         pop_mode = 0;
    int         pop_mode_left = 0;

    ode_integrator_euler_rk2_rk4 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_stop     (x_stop),
        .step_count (step_count),
        .empty      (empty),
        .pop        (pop),
        .y_final    (y_final),
        .overflow   (overflow)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint clip(longint v);
        if (v > longint'(Q_MAX))
        begin
            sat_seen = 1'b1;
            return longint'(Q_MAX);
        end
        if (v < longint'(Q_MIN))
        begin
            sat_seen = 1'b1;
            return longint'(Q_MIN);
        end
        return v;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clip(a + b);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint slope_at(longint x, longint y);
        longint p;
        if (equation_mirror)
            return qadd(x, y);
        p = qmul(y, qadd(x, longint'(Q_ONE)));
        return qadd(p, p);
    endfunction

    function automatic solution_t solve_ivp(logic signed [QW-1:0] xs, logic signed [QW-1:0] ys,
                                            logic signed [QW-1:0] xe, logic [CNT_W-1:0] cnt);
        solution_t r;
        longint    x;
        longint    y;
        longint    h;
        longint    xm;
        longint    k1;
        longint    k2;
        longint    k3;
        longint    k4;
        longint    s;
        int        n;
        x = xs;
        y = ys;
        n = (cnt > MAX_STEPS) ? MAX_STEPS : int'(cnt);
        sat_seen = 1'b0;
        h = (n == 0) ? 0 : clip((longint'(xe) - longint'(xs)) / longint'(n));
        for (int i = 0; i < n; i++)
        begin
            k1 = slope_at(x, y);
            if (method_mirror == METH_EULER)
                y = qadd(y, qmul(h, k1));
            else if (method_mirror == METH_RK2)
            begin
                k2 = slope_at(qadd(x, h), qadd(y, qmul(h, k1)));
                s = qadd(k1, k2);
                y = qadd(y, qmul(h, s) / 2);
            end
            else
            begin
                xm = qadd(x, h / 2);
                k2 = slope_at(xm, qadd(y, qmul(h, k1) / 2));
                k3 = slope_at(xm, qadd(y, qmul(h, k2) / 2));
                k4 = slope_at(qadd(x, h), qadd(y, qmul(h, k3)));
                s = qadd(k1, k2);
                s = qadd(s, k2);
                s = qadd(s, k3);
                s = qadd(s, k3);
                s = qadd(s, k4);
                y = qadd(y, qmul(h, s) / 6);
            end
            x = qadd(x, h);
        end
        r.y = y[QW-1:0];
        r.ovf = sat_seen;
        return r;
    endfunction

    task automatic report(string what, logic [QW-1:0] got, logic [QW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_solutions.size() == 0)
                report("unexpected word", y_final, '0);
            else
            begin
                want = pending_solutions.pop_front();
                if (y_final !== want.y)
                    report("y_final", y_final, want.y);
                if (overflow !== want.ovf)
                    report("overflow", {{(QW-1){1'b0}}, overflow}, {{(QW-1){1'b0}}, want.ovf});
            end
        end
    end

    always @(negedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode = $urandom_range(0, 2);
            pop_mode_left = $urandom_range(10, 200);
        end
        else
            pop_mode_left--;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_word(logic signed [QW-1:0] xs, logic signed [QW-1:0] ys,
                             logic signed [QW-1:0] xe, logic [CNT_W-1:0] cnt);
        x_start <= xs;
        y_start <= ys;
        x_stop <= xe;
        step_count <= cnt;
        push <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
            @(negedge clk);
        end
        pending_solutions.insert(pending_solutions.size(), solve_ivp(xs, ys, xe, cnt));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            push <= 1'b0;
            burst_left = $urandom_range(0, 6);
            repeat ($urandom_range(1, 30))
                @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_solutions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_METHOD)
            method_mirror = val;
        else
            equation_mirror = val[0];
    endtask

    function automatic logic signed [QW-1:0] rand_q();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            2: return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_word(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_8000, 11'd8);
        send_word(32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 11'd1);
    endtask

    task automatic test_extremes();
        send_word(Q_MIN, Q_MAX, Q_MAX, 11'd1);
        send_word(Q_MAX, Q_MIN, Q_MIN, 11'd3);
        send_word(Q_MIN, Q_MIN, Q_MIN, 11'd2);
        send_word(32'sh0000_0000, 32'sh7000_0000, 32'sh0010_0000, 11'd4);
        send_word(32'sh0001_0000, 32'sh0002_0000, 32'sh0000_0000, 11'd0);
        send_word(32'sh0000_0000, 32'sh0000_1000, 32'sh0000_4000, 11'd1024);
        send_word(32'sh0000_0000, 32'sh0000_1000, 32'sh0000_4000, 11'd2047);
        send_word(32'sh0000_0000, 32'shFFFF_F000, 32'sh0000_4000, 11'd1025);
    endtask

    task automatic test_methods();
        logic [1:0] meth;
        for (int m = 0; m < 4; m++)
        begin
            for (int e = 0; e < 2; e++)
            begin
                meth = 2'(m);
                write_reg(CFG_METHOD, meth);
                write_reg(CFG_EQUATION, {1'b0, e[0]});
                send_word(32'sh0000_0000, 32'sh0001_0000, 32'sh0001_0000, 11'd5);
                send_word(32'shFFFF_0000, 32'shFFFE_8000, 32'sh0000_8000, 11'd3);
            end
        end
    endtask

    task automatic test_random();
        logic [1:0]       meth;
        logic [CNT_W-1:0] cnt;
        for (int phase = 0; phase < 5; phase++)
        begin
            meth = (phase == 4) ? METH_RK4_ALT : phase[1:0];
            if (phase == 0)
                meth = METH_RK4;
            write_reg(CFG_METHOD, meth);
            write_reg(CFG_EQUATION, 2'($urandom_range(0, 1)));
            for (int i = 0; i < 15; i++)
            begin
                if (i == 7)
                    cnt = CNT_W'($urandom_range(1024, 2047));
                else if (i % 5 == 0)
                    cnt = CNT_W'($urandom_range(0, 63));
                else
                    cnt = CNT_W'($urandom_range(1, 12));
                send_word(rand_q(), rand_q(), rand_q(), cnt);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 2'd0;
        push = 1'b0;
        x_start = '0;
        y_start = '0;
        x_stop = '0;
        step_count = '0;
        method_mirror = METH_RK4;
        equation_mirror = 1'b0;
        burst_left = 0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_extremes();
        test_methods();
        test_random();
        wait_idle();
        if (mismatch_count == 0)
            $display("ode_integrator_euler_rk2_rk4 regression: pass");
        else
            $display("ode_integrator_euler_rk2_rk4 regression: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("ode_integrator_euler_rk2_rk4 regression: fail");
        $finish;
    end

endmodule
